### src/hop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the Hopalong orbit plotter.
// No dependencies; every other file of the block imports this package.

package hop_pkg;

    // Orbit state: signed Q24.16.
    localparam int ORB_W   = 40;
    // Coefficients: unsigned Q7.16.
    localparam int COEF_W  = 23;
    // |b*x - c| in Q.32 and its floor root in Q.16.
    localparam int MAG_W   = 63;
    localparam int ROOT_W  = 32;

    // Stream payload widths.
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 1;

    // Screen coordinate arithmetic.
    localparam int COORD_W = 24;
    localparam int PIX_W   = 11;
    localparam int OFS_W   = 24;

    localparam int DEF_SCREEN_WIDTH  = 400;
    localparam int DEF_SCREEN_HEIGHT = 240;

    localparam logic signed [ORB_W-1:0] ORBIT_START = 40'sd6554;
    localparam logic [COEF_W-1:0]       COEF_RESET  = 23'd65536;

    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_A = 2'd0,
        REG_COEF_B = 2'd1,
        REG_COEF_C = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

### src/hop_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// Multiply-accumulate unit: forms |b*x - c*2^16| with one shared 21x24 multiplier
// used twice (low and high half of x). Depends on hop_pkg.

module hop_mac (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [hop_pkg::ORB_W-1:0] i_x,
    input  wire logic [hop_pkg::COEF_W-1:0]      i_b,
    input  wire logic [hop_pkg::COEF_W-1:0]      i_c,
    output logic                                 o_done,
    output logic [hop_pkg::MAG_W-1:0]            o_mag
);
    import hop_pkg::*;

    localparam int HALF_W = ORB_W / 2;
    localparam int OPA_W  = HALF_W + 1;
    localparam int OPB_W  = COEF_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = 64;

    logic [2:0]               r_phase, n_phase;
    logic                     r_done;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [MAG_W-1:0]         r_mag;

    logic signed [OPA_W-1:0]  w_opa;
    logic signed [OPB_W-1:0]  w_opb;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_c_q32;
    logic [ACC_W-1:0]         w_neg;

    // Low half of x is unsigned, high half carries the sign.
    assign w_opa = (r_phase == 3'd1) ? $signed({1'b0, i_x[HALF_W-1:0]})
                                     : $signed({i_x[ORB_W-1], i_x[ORB_W-1:HALF_W]});
    assign w_opb = $signed({1'b0, i_b});
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_c_q32 = $signed({{(ACC_W-COEF_W-16){1'b0}}, i_c, 16'b0});
    assign w_neg = 64'd0 - r_acc;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            3'd0: n_phase = i_start ? 3'd1 : 3'd0;
            3'd1, 3'd2, 3'd3: n_phase = r_phase + 3'd1;
            default: n_phase = 3'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 3'd0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == 3'd4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == 3'd1 || r_phase == 3'd2) begin
            r_prod <= w_opa * w_opb;
        end
        if (r_phase == 3'd2) begin
            r_acc <= w_prod_ext - w_c_q32;
        end else if (r_phase == 3'd3) begin
            r_acc <= r_acc + (w_prod_ext <<< HALF_W);
        end
        if (r_phase == 3'd4) begin
            r_mag <= r_acc[ACC_W-1] ? w_neg[MAG_W-1:0] : r_acc[MAG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;

endmodule

`default_nettype wire

### src/hop_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring integer square root, one result bit per cycle.
// Depends on hop_pkg.

module hop_isqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [hop_pkg::MAG_W-1:0]  i_rad,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [hop_pkg::ROOT_W-1:0]      o_root
);
    import hop_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0]  w_rem_sh;
    logic [REM_W+1:0]  w_trial;
    logic              w_ge;
    logic [REM_W+1:0]  w_diff;

    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {1'b0, i_rad};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

### src/hopalong_orbit_plotter.sv
`timescale 1ns / 1ps
`default_nettype none
// Hopalong orbit plotter top level: sequencer, orbit state, screen mapping
// and output register. Depends on hop_pkg, hop_mac and hop_isqrt.
//
// The block advances the Hopalong map x' = y - sign(x)*sqrt(|b*x - c|),
// y' = a - x in signed Q24.16 and turns each new point into a pixel write.
// Input item (slave side): tuser[0] is the command (0 step, 1 restart at
// (0.1, 0.1)), tdata[7:0] the color byte. Each item gives exactly one result
// item on the master side: tuser[0] says the pixel is inside the screen, and
// tdata carries column, row, byte offset, the three color bytes and the
// saturation flag. Coefficients a, b and c are written through the plain
// write port (index 0, 1, 2); the user must write them only while the block
// is idle, which the block itself does not enforce. A step item runs from
// acceptance through the multiply-accumulate unit (two shared multiplier
// passes, accumulate, magnitude, done flag), the bit-serial square root, the
// update state and the output register load before the next acceptance. A
// restart item goes straight to the done state, then loads the output register.
// The input is taken only while the sequencer is idle; a result waiting in the
// output register does not block acceptance, but a finished item holds in the
// last state until the output register frees up when the receiver stalls.
// Reset (synchronous, active low) sets the coefficients to 1.0, the orbit to
// (0.1, 0.1) and empties the output register.

module hopalong_orbit_plotter #(
    parameter int SCREEN_WIDTH  = hop_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = hop_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [hop_pkg::REG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [hop_pkg::COEF_W-1:0]         i_cfg_wdata,
    // Input channel.
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: [7:0] color
    input  wire logic [hop_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: [0] cmd
    input  wire logic [hop_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    // Output channel.
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: [8:0] column, [16:9] row, [35:17] byte_offset, [43:36] chan0_value,
    //        [51:44] chan1_value, [59:52] chan2_value, [60] saturated, [63:61] zero
    output logic [hop_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    // tuser: [0] plot
    output logic [hop_pkg::OUT_USER_W-1:0]          o_m_axis_tuser
);
    import hop_pkg::*;

    localparam int SUM_W = ORB_W + 2;
    localparam logic signed [COORD_W-1:0] HALF_W_S = COORD_W'(SCREEN_WIDTH / 2);
    localparam logic signed [COORD_W-1:0] HALF_H_S = COORD_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [COORD_W-1:0] SCR_W_S  = COORD_W'(SCREEN_WIDTH);
    localparam logic signed [COORD_W-1:0] SCR_H_S  = COORD_W'(SCREEN_HEIGHT);
    localparam logic signed [SUM_W-1:0] ORB_MAX_S = $signed({2'b00, 1'b0, {(ORB_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] ORB_MIN_S = $signed({2'b11, 1'b1, {(ORB_W-1){1'b0}}});

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MAC    = 5'b00010,
        S_ROOT   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [COEF_W-1:0]         r_coef_a, r_coef_b, r_coef_c;
    logic signed [ORB_W-1:0]   r_x, r_y;
    logic [IN_DATA_W-1:0]      r_color;
    logic                      r_hit;
    logic signed [COORD_W-1:0] r_col, r_row;

    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic [OUT_USER_W-1:0]     r_out_user;

    logic                      w_in_acc;
    logic                      w_restart;
    logic                      w_out_free;

    logic                      w_mac_done;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_root_busy;
    logic                      w_root_done;
    logic [ROOT_W-1:0]         w_root;

    logic signed [SUM_W-1:0]   w_t;
    logic signed [SUM_W-1:0]   w_nx_sum, w_ny_sum;
    logic signed [ORB_W-1:0]   w_nx, w_ny;
    logic                      w_nx_hit, w_ny_hit;
    logic signed [COORD_W-1:0] w_col, w_row;

    logic                      w_plot;
    logic [PIX_W-1:0]          w_col_pix, w_row_pix;
    logic [OFS_W-1:0]          w_lin, w_off;
    logic [OUT_DATA_W-1:0]     w_data;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_restart  = i_s_axis_tuser[0];
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    hop_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc && !w_restart),
        .i_x     (r_x),
        .i_b     (r_coef_b),
        .i_c     (r_coef_c),
        .o_done  (w_mac_done),
        .o_mag   (w_mag)
    );

    hop_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_done),
        .i_rad   (w_mag),
        .o_busy  (w_root_busy),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // Orbit update. x = 0 counts as positive, so it subtracts the root.
    assign w_t      = $signed({{(SUM_W-ROOT_W){1'b0}}, w_root});
    assign w_nx_sum = r_x[ORB_W-1] ? $signed({{2{r_y[ORB_W-1]}}, r_y}) + w_t
                                   : $signed({{2{r_y[ORB_W-1]}}, r_y}) - w_t;
    assign w_ny_sum = $signed({{(SUM_W-COEF_W){1'b0}}, r_coef_a})
                    - $signed({{2{r_x[ORB_W-1]}}, r_x});

    always_comb begin
        w_nx_hit = 1'b0;
        w_ny_hit = 1'b0;
        w_nx = w_nx_sum[ORB_W-1:0];
        w_ny = w_ny_sum[ORB_W-1:0];
        if (w_nx_sum > ORB_MAX_S) begin
            w_nx = ORB_MAX_S[ORB_W-1:0];
            w_nx_hit = 1'b1;
        end else if (w_nx_sum < ORB_MIN_S) begin
            w_nx = ORB_MIN_S[ORB_W-1:0];
            w_nx_hit = 1'b1;
        end
        if (w_ny_sum > ORB_MAX_S) begin
            w_ny = ORB_MAX_S[ORB_W-1:0];
            w_ny_hit = 1'b1;
        end else if (w_ny_sum < ORB_MIN_S) begin
            w_ny = ORB_MIN_S[ORB_W-1:0];
            w_ny_hit = 1'b1;
        end
    end

    // The arithmetic shift by 17 is floor(v / 2^17), which halves the Q.16 value.
    assign w_col = HALF_W_S + $signed({w_nx[ORB_W-1], w_nx[ORB_W-1:17]});
    assign w_row = HALF_H_S + $signed({w_ny[ORB_W-1], w_ny[ORB_W-1:17]});

    // Screen mapping of the registered point, inside the screen with row 0 and column 0 excluded.
    assign w_plot = (r_col >= COORD_W'(1)) && (r_col < SCR_W_S)
                 && (r_row >= COORD_W'(1)) && (r_row < SCR_H_S);
    assign w_col_pix = r_col[PIX_W-1:0];
    assign w_row_pix = r_row[PIX_W-1:0];
    assign w_lin = OFS_W'(w_row_pix) + OFS_W'(w_col_pix) * OFS_W'(SCREEN_HEIGHT);
    assign w_off = (w_lin << 1) + w_lin;

    always_comb begin
        w_data = '0;
        w_data[60] = r_hit;
        if (w_plot) begin
            w_data[8:0]   = r_col[8:0];
            w_data[16:9]  = r_row[7:0];
            w_data[35:17] = w_off[18:0];
            w_data[43:36] = r_color;
            w_data[51:44] = {r_color[6:0], 1'b0};
            w_data[59:52] = {r_color[5:0], 2'b00};
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_restart ? S_DONE : S_MAC;
                end
            end
            S_MAC: begin
                if (w_mac_done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (w_root_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_coef_a    <= COEF_RESET;
            r_coef_b    <= COEF_RESET;
            r_coef_c    <= COEF_RESET;
            r_x         <= ORBIT_START;
            r_y         <= ORBIT_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_addr))
                    REG_COEF_A: r_coef_a <= i_cfg_wdata;
                    REG_COEF_B: r_coef_b <= i_cfg_wdata;
                    REG_COEF_C: r_coef_c <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_in_acc && w_restart) begin
                r_x <= ORBIT_START;
                r_y <= ORBIT_START;
            end else if (r_state == S_UPDATE) begin
                r_x <= w_nx;
                r_y <= w_ny;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_color <= i_s_axis_tdata;
            // A restart leaves an off-screen point with no saturation.
            r_hit   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else if (r_state == S_UPDATE) begin
            r_hit <= w_nx_hit || w_ny_hit;
            r_col <= w_col;
            r_row <= w_row;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= w_data;
            r_out_user <= OUT_USER_W'(w_plot);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // An off-screen result carries nothing but the saturation flag.
    a_offscreen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[59:0] == 60'd0))
        else $error("off-screen result carries pixel fields");

    // A restart puts the orbit back at its start point.
    a_restart_orbit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_restart) |=> (r_x == ORBIT_START && r_y == ORBIT_START))
        else $error("restart did not reset the orbit");

    // The root unit is never busy while the block takes a new item.
    a_root_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_root_busy)
        else $error("square root busy while accepting");

    // The multiply-accumulate result only arrives while the sequencer waits for it.
    a_mac_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == S_MAC))
        else $error("multiply result outside its state");

endmodule

`default_nettype wire

### tb/hopalong_orbit_plotter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hopalong_orbit_plotter: drives step and restart items,
// predicts every pixel write in a scoreboard class and checks each output field.
// Depends on hop_pkg and the plotter RTL.

module hopalong_orbit_plotter_tb;
    import hop_pkg::*;

    // The block is built with its default screen size.
    localparam int SCR_W = DEF_SCREEN_WIDTH;
    localparam int SCR_H = DEF_SCREEN_HEIGHT;

    // The orbit saturates to the signed 40-bit range.
    localparam longint ORB_HI = 64'sd549755813887;
    localparam longint ORB_LO = -ORB_HI - 1;

    // Coefficient corners: the nominal range 1.0 .. 100.0 and the full register width.
    localparam logic [COEF_W-1:0] COEF_LOW  = 23'd65536;
    localparam logic [COEF_W-1:0] COEF_HIGH = 23'd6553600;
    localparam logic [COEF_W-1:0] COEF_ALL  = 23'h7FFFFF;

    // Anything quiet for far longer than a step or the long receiver hold
    // is a hang.
    localparam int STALL_LIMIT    = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL     = 60;
    localparam int ITEMS_PER_SET  = 70;
    localparam int SETS_PER_PHASE = 5;
    localparam int RESTART_PCT    = 4;
    localparam int MAX_PRINTED    = 100;

    // One expected pixel write, laid out like the output fields.
    typedef struct packed {
        logic        plot;
        logic [8:0]  column;
        logic [7:0]  row;
        logic [18:0] offset;
        logic [7:0]  chan0;
        logic [7:0]  chan1;
        logic [7:0]  chan2;
        logic        sat;
    } t_pixel_write;

    // Scoreboard: keeps its own copy of the orbit and the coefficients, turns
    // every accepted item into the pixel write it must produce, and checks the
    // block's results against those in order.
    class pixel_write_checker;
        longint       coef_a, coef_b, coef_c;
        longint       orbit_x, orbit_y;
        t_pixel_write expected_pixels[$];
        int           n_results;
        int           errors;

        function new();
            coef_a    = COEF_RESET;
            coef_b    = COEF_RESET;
            coef_c    = COEF_RESET;
            orbit_x   = ORBIT_START;
            orbit_y   = ORBIT_START;
            n_results = 0;
            errors    = 0;
        endfunction

        function void set_coef(t_reg_idx idx, logic [COEF_W-1:0] val);
            case (idx)
                REG_COEF_A: coef_a = val;
                REG_COEF_B: coef_b = val;
                REG_COEF_C: coef_c = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Floor square root, one result bit per pass.
        function logic [31:0] floor_sqrt(longint unsigned v);
            longint unsigned rem, acc, probe;
            rem   = v;
            acc   = 0;
            probe = 64'h1 << 62;
            while (probe > rem) probe = probe >> 2;
            while (probe != 0) begin
                if (rem >= acc + probe) begin
                    rem = rem - (acc + probe);
                    acc = (acc >> 1) + probe;
                end else begin
                    acc = acc >> 1;
                end
                probe = probe >> 2;
            end
            return acc[31:0];
        endfunction

        function void predict_pixel(logic cmd, logic [7:0] color);
            t_pixel_write    px;
            longint          diff, root, nx, ny, col, row, ofs;
            longint unsigned mag;
            px = '0;
            if (cmd) begin
                // Restart gives an all-zero result.
                orbit_x = ORBIT_START;
                orbit_y = ORBIT_START;
            end else begin
                // b*x is Q.32, so c is lifted to Q.32 before the subtraction.
                diff = coef_b * orbit_x - coef_c * 65536;
                mag  = (diff < 0) ? -diff : diff;
                root = floor_sqrt(mag);
                // x = 0 counts as positive.
                nx = (orbit_x < 0) ? orbit_y + root : orbit_y - root;
                ny = coef_a - orbit_x;
                px.sat = (nx > ORB_HI) || (nx < ORB_LO) || (ny > ORB_HI) || (ny < ORB_LO);
                if (nx > ORB_HI) nx = ORB_HI;
                else if (nx < ORB_LO) nx = ORB_LO;
                if (ny > ORB_HI) ny = ORB_HI;
                else if (ny < ORB_LO) ny = ORB_LO;
                orbit_x = nx;
                orbit_y = ny;
                // Half of a Q.16 value in whole pixels, rounded toward minus infinity.
                col = SCR_W / 2 + (nx >>> 17);
                row = SCR_H / 2 + (ny >>> 17);
                if (col >= 1 && col < SCR_W && row >= 1 && row < SCR_H) begin
                    ofs       = 3 * (row + col * SCR_H);
                    px.plot   = 1'b1;
                    px.column = col[8:0];
                    px.row    = row[7:0];
                    px.offset = ofs[18:0];
                    px.chan0  = color;
                    px.chan1  = {color[6:0], 1'b0};
                    px.chan2  = {color[5:0], 2'b00};
                end
            end
            expected_pixels.push_back(px);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("%0t ns: result %0d: %s", $time, n_results, what);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_pixel(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_pixel_write want;
            if (expected_pixels.size() == 0) begin
                report_mismatch("result item arrived with nothing expected");
            end else begin
                want = expected_pixels.pop_front();
                compare_field("plot", user[0], want.plot);
                compare_field("column", data[8:0], want.column);
                compare_field("row", data[16:9], want.row);
                compare_field("byte_offset", data[35:17], want.offset);
                compare_field("chan0_value", data[43:36], want.chan0);
                compare_field("chan1_value", data[51:44], want.chan1);
                compare_field("chan2_value", data[59:52], want.chan2);
                compare_field("saturated", data[60], want.sat);
                compare_field("padding", data[63:61], 64'd0);
                n_results++;
            end
        endtask
    endclass

    pixel_write_checker pixel_check = new();

    // Every input of the block starts at a known value.
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_reg_idx              cfg_addr  = REG_COEF_A;
    logic [COEF_W-1:0]     cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [IN_DATA_W-1:0]  in_color  = '0;
    logic [IN_USER_W-1:0]  in_cmd    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_DATA_W-1:0] out_data;
    logic [OUT_USER_W-1:0] out_user;

    // Idle chances in percent per cycle, set by the stimulus process per phase.
    int src_idle_pct = 0;
    int rx_idle_pct  = 0;
    // Bumped by the stimulus process to ask the receiver for one long hold.
    int hold_req     = 0;
    // Cycles since the last accepted item on either side.
    int quiet_cycles = 0;

    hopalong_orbit_plotter i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_color),   // [7:0] color
        .i_s_axis_tuser  (in_cmd),     // [0] cmd
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),   // [8:0] column .. [60] saturated
        .o_m_axis_tuser  (out_user)    // [0] plot
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stalls at random at the current rate, and when asked it holds
    // off for a long stretch so the block's output register backs up into its
    // input while the sender keeps offering items.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Result checking and the hang watchdog, both on the rising edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) pixel_check.check_pixel(out_data, out_user);
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one item, idling first at the sender's current rate, and returns
    // at the falling edge after it was taken. Valid stays high between items
    // unless the next call idles.
    task automatic send_item(logic cmd, logic [7:0] color);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_color <= color;
        do @(posedge clk); while (!in_ready);
        pixel_check.predict_pixel(cmd, color);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        send_item($urandom_range(0, 99) < RESTART_PCT, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (pixel_check.pending() != 0) @(negedge clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [COEF_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        pixel_check.set_coef(idx, val);
        @(negedge clk);
    endtask

    // Coefficients change only with the block idle: the sender pauses, every
    // expected result is collected, and a few spare cycles let the sequencer
    // return to idle before the writes.
    task automatic load_coefs(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                              logic [COEF_W-1:0] c);
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(negedge clk);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        cfg_we <= 1'b0;
    endtask

    // Mostly nominal coefficients, with the range ends and arbitrary 23-bit
    // values mixed in.
    function automatic logic [COEF_W-1:0] pick_coef();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return COEF_LOW;
        if (roll < 16) return COEF_HIGH;
        if (roll < 28) return COEF_W'($urandom);
        return COEF_W'($urandom_range(COEF_LOW, COEF_HIGH));
    endfunction

    initial begin
        int ph;
        int set_no;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 11;
        rx_idle_pct  = 61;

        // Directed part. With the reset coefficients of 1.0 the orbit stays near
        // the screen center, so these steps plot; colors cover all-zero, all-one
        // and alternating bits so the shifted color bytes drop their top bits.
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hAA);
        send_item(1'b0, 8'h55);
        // A restart gives an off-screen, all-zero result even with a color offered.
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h80);

        // The corners of the nominal coefficient range.
        load_coefs(COEF_HIGH, COEF_HIGH, COEF_HIGH);
        repeat (3) send_item(1'b0, 8'($urandom));
        load_coefs(COEF_LOW, COEF_LOW, COEF_HIGH);
        repeat (3) send_item(1'b0, 8'($urandom));

        // Register values outside the nominal range are used as written,
        // zero and all-ones included.
        load_coefs('0, COEF_ALL, '0);
        repeat (3) send_item(1'b0, 8'($urandom));
        load_coefs(COEF_ALL, '0, COEF_ALL);
        send_item(1'b1, 8'h00);
        repeat (3) send_item(1'b0, 8'($urandom));
        // Back-to-back restarts.
        send_item(1'b1, 8'h7F);
        send_item(1'b1, 8'h01);

        // Random part in three idling phases: sender light and receiver heavy,
        // then the reverse, then no idling at all. Each set of items runs with
        // fresh coefficients, and in the last phase the receiver once holds off
        // long enough that the block stops taking input.
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 11;
                    rx_idle_pct  = 61;
                end
                1: begin
                    src_idle_pct = 61;
                    rx_idle_pct  = 11;
                end
                default: begin
                    src_idle_pct = 0;
                    rx_idle_pct  = 0;
                end
            endcase
            for (set_no = 0; set_no < SETS_PER_PHASE; set_no++) begin
                load_coefs(pick_coef(), pick_coef(), pick_coef());
                if (ph == 2 && set_no == 1) hold_req++;
                repeat (ITEMS_PER_SET) send_random_item();
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        // The drain tail outlasts a step, so any stray result would show up.
        repeat (DRAIN_TAIL) @(negedge clk);

        if (pixel_check.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
